/* rtl/great_circle_distance_core_defines.svh */
// assertion macros for the great-circle distance core
`ifndef GREAT_CIRCLE_DISTANCE_CORE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define GCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcd: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define GCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcd: next-cycle check failed");

`else

`define GCD_ASSERT_IMP(lbl, ante, cons)

`define GCD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* rtl/gcd_pkg.sv */
// shared types, constants and helper functions for the great-circle distance core
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 24;

    localparam int Q_BITS  = 30;
    localparam int ANGLE_W = 32;
    localparam int TRIG_W  = 32;
    localparam int ROOT_W  = 31;
    localparam int DIST_W  = 25;
    localparam int ACC_W   = 34;

    localparam logic [DIST_W-1:0]      DIST_MAX    = 25'd20015087;
    localparam logic [23:0]            TWO_RADIUS  = 24'd12742000;
    localparam logic signed [31:0]     HALF_PI_Q30 = 32'sd1686629713;
    localparam logic signed [ACC_W-1:0] GAIN_Q30   = 34'sd652032874;
    localparam logic [ROOT_W-1:0]      ONE_Q30     = 31'h4000_0000;
    // ceil(2^32 / 90), exact quotient for dividends below 2^26
    localparam logic [25:0]            DIV90_RECIP = 26'd47721859;

    typedef logic [ANGLE_W-1:0]        turn_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic [ROOT_W-1:0]         root_t;
    typedef logic [ANGLE_W-1:0]        frac_tab_t [90];

    function automatic logic signed [ACC_W-1:0] atan_q30(input int i);
        logic signed [ACC_W-1:0] v;
        case (i)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048576;
            default: v = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return v;
    endfunction

    // rounded (b * 2^s) / 360 for the remainder of a divide by 90
    function automatic frac_tab_t make_frac_tab(input int s);
        frac_tab_t tab;
        longint    num;
        for (int b = 0; b < 90; b++)
        begin
            num    = (longint'(b) << s) + 64'sd180;
            tab[b] = ANGLE_W'(num / 360);
        end
        return tab;
    endfunction

    // shift right by 30, rounding half away from zero
    function automatic logic signed [63:0] rsh30(input logic signed [63:0] p);
        logic signed [63:0] bias;
        bias = p[63] ? 64'sd536870911 : 64'sd536870912;
        return (p + bias) >>> Q_BITS;
    endfunction

endpackage

/* rtl/great_circle_distance_core.sv */
// top level: haversine great-circle distance pipeline with output skid stage
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  in       | in_valid / in_stall  | lat_a, lon_a, lat_b, lon_b
//  out      | out_valid / out_stall| distance_m
//
// the depth is set by the two cordic chains and the 31-stage square root;
// one item per cycle while in_stall is low
// the pipeline moves as a whole; the skid register catches one item when
// the output is stalled, and in_stall rises while it is full
// reset clears only the valid bits and the skid/output flags
`include "great_circle_distance_core_defines.svh"

module great_circle_distance_core #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = gcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [23:0]          lat_a,
    input  logic signed [24:0]          lon_a,
    input  logic signed [23:0]          lat_b,
    input  logic signed [24:0]          lon_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gcd_pkg::DIST_W-1:0]  distance_m
);
    import gcd_pkg::*;

    logic              en;
    logic              ang_valid, rot_valid, hav_valid, sqrt_valid, pipe_valid;
    turn_t             turn [4];
    trig_t             trig [4];
    root_t             hav, hav_c;
    root_t             rad [2];
    root_t             root [2];
    logic [DIST_W-1:0] pipe_dist;

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DIST_W-1:0] out_data_reg, skid_data_reg;
    logic              out_free, incoming, out_load, out_from_skid, skid_load;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    gcd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .lat_a     (lat_a),
        .lon_a     (lon_a),
        .lat_b     (lat_b),
        .lon_b     (lon_b),
        .turn      (turn),
        .out_valid (ang_valid)
    );

    gcd_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ang_valid),
        .turn      (turn),
        .trig      (trig),
        .out_valid (rot_valid)
    );

    gcd_hav u_hav (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .trig      (trig),
        .hav       (hav),
        .hav_c     (hav_c),
        .out_valid (hav_valid)
    );

    assign rad[0] = hav;
    assign rad[1] = hav_c;

    gcd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hav_valid),
        .rad       (rad),
        .root      (root),
        .out_valid (sqrt_valid)
    );

    gcd_vec #(.CORDIC_STEPS(CORDIC_STEPS)) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .y_in      (root[0]),
        .x_in      (root[1]),
        .distance  (pipe_dist),
        .out_valid (pipe_valid)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign incoming = en && pipe_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        out_from_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                out_load        = 1'b1;
                out_from_skid   = 1'b1;
            end
        end
        else if (incoming)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_load       = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_load       = 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= out_from_skid ? skid_data_reg : pipe_dist;
        if (skid_load)
            skid_data_reg <= pipe_dist;
    end

    assign out_valid  = out_valid_reg;
    assign distance_m = out_data_reg;

    `GCD_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `GCD_ASSERT_NXT(a_skid_fills, !skid_valid_reg && pipe_valid && out_valid_reg && out_stall, skid_valid_reg)
    `GCD_ASSERT_NXT(a_skid_drains, skid_valid_reg && !out_stall, out_valid_reg && !skid_valid_reg)
    `GCD_ASSERT_IMP(a_dist_range, out_valid_reg, distance_m <= DIST_MAX)

endmodule

/* rtl/gcd_angle.sv */
// degree inputs to wrapped 32-bit binary angles, four lanes
module gcd_angle #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [23:0]  lat_a,
    input  logic signed [24:0]  lon_a,
    input  logic signed [23:0]  lat_b,
    input  logic signed [24:0]  lon_b,
    output gcd_pkg::turn_t      turn [4],
    output logic                out_valid
);
    import gcd_pkg::*;

    localparam int LANES   = 4;
    localparam int MAG_W   = 26;
    localparam int QUO_W   = 19;
    localparam int REM_W   = 7;
    localparam int SH_HALF = 31 - ANGLE_FRAC_BITS;
    localparam int SH_FULL = 32 - ANGLE_FRAC_BITS;

    logic [3:0]              vld_reg;
    logic signed [MAG_W-1:0] d [LANES];

    assign d[0] = MAG_W'(lat_b) - MAG_W'(lat_a);
    assign d[1] = MAG_W'(lon_b) - MAG_W'(lon_a);
    assign d[2] = MAG_W'(lat_a);
    assign d[3] = MAG_W'(lat_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    assign out_valid = vld_reg[3];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        localparam int        SH  = (g < 2) ? SH_HALF : SH_FULL;
        localparam frac_tab_t TAB = make_frac_tab(SH);

        logic [MAG_W-1:0]   mag_a_reg, mag_b_reg, mag_next;
        logic               neg_a_reg, neg_b_reg, neg_c_reg;
        logic [QUO_W-1:0]   quo_b_reg, quo_c_reg, quo_next;
        logic [REM_W-1:0]   rem_c_reg, rem_next;
        logic [2*MAG_W-1:0] prod;
        turn_t              mag_turn, turn_reg, turn_next;

        assign mag_next = d[g][MAG_W-1] ? MAG_W'(-d[g]) : MAG_W'(d[g]);
        assign prod     = (2*MAG_W)'(mag_a_reg) * (2*MAG_W)'(DIV90_RECIP);
        assign quo_next = prod[32 +: QUO_W];
        assign rem_next = REM_W'(mag_b_reg - MAG_W'(quo_b_reg) * MAG_W'(90));
        // table part stays below the shifted quotient, so the two just merge
        assign mag_turn  = (turn_t'(quo_c_reg) << (SH - 2)) | TAB[rem_c_reg];
        assign turn_next = neg_c_reg ? -mag_turn : mag_turn;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_a_reg <= mag_next;
                neg_a_reg <= d[g][MAG_W-1];
                mag_b_reg <= mag_a_reg;
                neg_b_reg <= neg_a_reg;
                quo_b_reg <= quo_next;
                rem_c_reg <= rem_next;
                quo_c_reg <= quo_b_reg;
                neg_c_reg <= neg_b_reg;
                turn_reg  <= turn_next;
            end
        end

        assign turn[g] = turn_reg;
    end

endmodule

/* rtl/gcd_rot.sv */
// rotation cordic: sine of lanes 0 and 1, cosine of lanes 2 and 3
module gcd_rot #(
    parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  gcd_pkg::turn_t turn [4],
    output gcd_pkg::trig_t trig [4],
    output logic           out_valid
);
    import gcd_pkg::*;

    localparam int LANES = 4;
    localparam int N     = CORDIC_STEPS;

    logic [N+2:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N+1:0], in_valid};
    end

    assign out_valid = vld_reg[N+2];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic                    flip_reg [N+2];
        logic                    flip_in;
        logic signed [31:0]      st;
        logic signed [63:0]      prod_reg, prod_next;
        logic signed [ACC_W-1:0] z0_reg, z0_next;
        logic signed [ACC_W-1:0] x_w [N+1];
        logic signed [ACC_W-1:0] y_w [N+1];
        logic signed [ACC_W-1:0] z_w [N+1];
        logic signed [ACC_W-1:0] x_reg [N];
        logic signed [ACC_W-1:0] y_reg [N];
        logic signed [ACC_W-1:0] z_reg [N];
        logic signed [ACC_W-1:0] pick;
        trig_t                   trig_reg, trig_next;

        // fold into the right half plane; the fold negates both outputs
        assign flip_in   = turn[g][31] ^ turn[g][30];
        assign st        = {turn[g][30], turn[g][30:0]};
        assign prod_next = 64'(st) * 64'(HALF_PI_Q30);
        assign z0_next   = ACC_W'(rsh30(prod_reg));

        assign x_w[0] = GAIN_Q30;
        assign y_w[0] = '0;
        assign z_w[0] = z0_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg    <= prod_next;
                flip_reg[0] <= flip_in;
                z0_reg      <= z0_next;
                flip_reg[1] <= flip_reg[0];
            end
        end

        for (genvar k = 0; k < N; k++)
        begin : g_step
            logic signed [ACC_W-1:0] xs, ys, x_next, y_next, z_next;

            assign xs     = x_w[k] >>> k;
            assign ys     = y_w[k] >>> k;
            assign x_next = z_w[k][ACC_W-1] ? x_w[k] + ys : x_w[k] - ys;
            assign y_next = z_w[k][ACC_W-1] ? y_w[k] - xs : y_w[k] + xs;
            assign z_next = z_w[k][ACC_W-1] ? z_w[k] + atan_q30(k) : z_w[k] - atan_q30(k);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]      <= x_next;
                    y_reg[k]      <= y_next;
                    z_reg[k]      <= z_next;
                    flip_reg[k+2] <= flip_reg[k+1];
                end
            end

            assign x_w[k+1] = x_reg[k];
            assign y_w[k+1] = y_reg[k];
            assign z_w[k+1] = z_reg[k];
        end

        assign pick      = (g < 2) ? y_w[N] : x_w[N];
        assign trig_next = flip_reg[N+1] ? TRIG_W'(-pick) : TRIG_W'(pick);

        always_ff @(posedge clk)
        begin
            if (en)
                trig_reg <= trig_next;
        end

        assign trig[g] = trig_reg;
    end

endmodule

/* rtl/gcd_hav.sv */
// haversine term a and 1 - a from the sines and cosines, clamped to 0..1
module gcd_hav (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  gcd_pkg::trig_t  trig [4],
    output gcd_pkg::root_t  hav,
    output gcd_pkg::root_t  hav_c,
    output logic            out_valid
);
    import gcd_pkg::*;

    logic [5:0]          vld_reg;
    logic signed [63:0]  pcc_reg, plon_reg, plat_reg;
    logic signed [32:0]  t_reg, u_reg, v2_reg, v3_reg, v4_reg;
    logic signed [63:0]  tu_reg;
    logic signed [33:0]  w_reg;
    logic signed [34:0]  sum;
    root_t               a_reg, a_next, a6_reg, na_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    assign sum = 35'(v4_reg) + 35'(w_reg);

    always_comb
    begin
        if (sum[34])
            a_next = '0;
        else if (sum > 35'(ONE_Q30))
            a_next = ONE_Q30;
        else
            a_next = ROOT_W'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcc_reg  <= 64'(trig[2]) * 64'(trig[3]);
            plon_reg <= 64'(trig[1]) * 64'(trig[1]);
            plat_reg <= 64'(trig[0]) * 64'(trig[0]);
            t_reg    <= 33'(rsh30(pcc_reg));
            u_reg    <= 33'(rsh30(plon_reg));
            v2_reg   <= 33'(rsh30(plat_reg));
            tu_reg   <= 64'(t_reg) * 64'(u_reg);
            v3_reg   <= v2_reg;
            w_reg    <= 34'(rsh30(tu_reg));
            v4_reg   <= v3_reg;
            a_reg    <= a_next;
            a6_reg   <= a_reg;
            na_reg   <= ONE_Q30 - a_reg;
        end
    end

    assign hav       = a6_reg;
    assign hav_c     = na_reg;
    assign out_valid = vld_reg[5];

endmodule

/* rtl/gcd_sqrt.sv */
// rounded square roots of two q30 values, one result bit per stage
module gcd_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  gcd_pkg::root_t rad [2],
    output gcd_pkg::root_t root [2],
    output logic           out_valid
);
    import gcd_pkg::*;

    localparam int LANES = 2;
    localparam int ITER  = 31;
    localparam int N_W   = 62;

    logic [ITER:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[ITER-1:0], in_valid};
    end

    assign out_valid = vld_reg[ITER];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [N_W-1:0] n_w [ITER+1];
        logic [N_W-1:0] r_w [ITER+1];
        logic [N_W-1:0] n_reg [ITER];
        logic [N_W-1:0] r_reg [ITER];
        root_t          root_reg, root_next;

        assign n_w[0] = N_W'(rad[g]) << Q_BITS;
        assign r_w[0] = '0;

        for (genvar k = 0; k < ITER; k++)
        begin : g_step
            localparam logic [N_W-1:0] BIT = N_W'(1) << (2 * (ITER - 1 - k));

            logic [N_W-1:0] trial, n_next, r_next;
            logic           fits;

            assign trial  = r_w[k] + BIT;
            assign fits   = n_w[k] >= trial;
            assign n_next = fits ? n_w[k] - trial : n_w[k];
            assign r_next = fits ? (r_w[k] >> 1) + BIT : r_w[k] >> 1;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k] <= n_next;
                    r_reg[k] <= r_next;
                end
            end

            assign n_w[k+1] = n_reg[k];
            assign r_w[k+1] = r_reg[k];
        end

        // round to nearest: remainder above the root means the upper neighbor
        assign root_next = ROOT_W'(r_w[ITER] + N_W'(n_w[ITER] > r_w[ITER]));

        always_ff @(posedge clk)
        begin
            if (en)
                root_reg <= root_next;
        end

        assign root[g] = root_reg;
    end

endmodule

/* rtl/gcd_vec.sv */
// vectoring cordic atan2 and scaling of the central angle to metres
module gcd_vec #(
    parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  gcd_pkg::root_t               y_in,
    input  gcd_pkg::root_t               x_in,
    output logic [gcd_pkg::DIST_W-1:0]   distance,
    output logic                         out_valid
);
    import gcd_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic [N+2:0]            vld_reg;
    logic signed [ACC_W-1:0] x_w [N+1];
    logic signed [ACC_W-1:0] y_w [N+1];
    logic signed [ACC_W-1:0] z_w [N+1];
    logic signed [ACC_W-1:0] x_reg [N];
    logic signed [ACC_W-1:0] y_reg [N];
    logic signed [ACC_W-1:0] z_reg [N];
    logic [ROOT_W-1:0]       zc_reg, zc_next;
    logic [55:0]             p_reg;
    logic [26:0]             d_full;
    logic [DIST_W-1:0]       d_reg, d_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N+1:0], in_valid};
    end

    assign x_w[0] = ACC_W'(x_in);
    assign y_w[0] = ACC_W'(y_in);
    assign z_w[0] = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic signed [ACC_W-1:0] xs, ys, x_next, y_next, z_next;

        assign xs     = x_w[k] >>> k;
        assign ys     = y_w[k] >>> k;
        assign x_next = y_w[k][ACC_W-1] ? x_w[k] - ys : x_w[k] + ys;
        assign y_next = y_w[k][ACC_W-1] ? y_w[k] + xs : y_w[k] - xs;
        assign z_next = y_w[k][ACC_W-1] ? z_w[k] - atan_q30(k) : z_w[k] + atan_q30(k);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= x_next;
                y_reg[k] <= y_next;
                z_reg[k] <= z_next;
            end
        end

        assign x_w[k+1] = x_reg[k];
        assign y_w[k+1] = y_reg[k];
        assign z_w[k+1] = z_reg[k];
    end

    assign zc_next = z_w[N][ACC_W-1] ? '0 : ROOT_W'(z_w[N]);
    assign d_full  = 27'((p_reg + 56'd536870912) >> Q_BITS);
    assign d_next  = (d_full > 27'(DIST_MAX)) ? DIST_MAX : DIST_W'(d_full);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zc_reg <= zc_next;
            p_reg  <= 56'(zc_reg) * 56'(TWO_RADIUS);
            d_reg  <= d_next;
        end
    end

    assign distance  = d_reg;
    assign out_valid = vld_reg[N+2];

endmodule
